FILE: sv/pixel_color_effects_macros.svh
// Assertion macros for the pixel color effects block.
// Used by pixel_color_effects.sv; define NO_ASSERTIONS to drop the checks.
`ifndef PIXEL_COLOR_EFFECTS_MACROS_SVH
`define PIXEL_COLOR_EFFECTS_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pixel_color_effects: check failed");
`define PCE_ASSERT_NEXT(lbl, clk, rstn, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) \
    else $error("pixel_color_effects: check failed");
`else
`define PCE_ASSERT(lbl, clk, rstn, prop)
`define PCE_ASSERT_NEXT(lbl, clk, rstn, cond, nxt)
`endif
`endif

FILE: sv/pce_pkg.sv
// Shared types and constants of the pixel color effects block.
// No dependencies.
package pce_pkg;

  typedef enum logic [2:0] {
    MODE_INVERT  = 3'd0,
    MODE_DECOLOR = 3'd1,
    MODE_SEPIA   = 3'd2,
    MODE_CAST    = 3'd3,
    MODE_FREEZE  = 3'd4,
    MODE_COMIC   = 3'd5
  } mode_t;

  localparam int DIV_STEPS = 8;
  localparam logic [7:0] MAXV = 8'd255;

  // floor(y/125) = (y * SEP_RECIP) >> SEP_SHIFT for y < 59124
  localparam logic [15:0] SEP_RECIP = 16'd33555;
  localparam int SEP_SHIFT = 22;

  localparam logic [9:0] SEP_R0 = 10'd393, SEP_G0 = 10'd769, SEP_B0 = 10'd189;
  localparam logic [9:0] SEP_R1 = 10'd349, SEP_G1 = 10'd686, SEP_B1 = 10'd168;
  localparam logic [9:0] SEP_R2 = 10'd272, SEP_G2 = 10'd534, SEP_B2 = 10'd131;

  typedef struct packed {
    mode_t            mode;
    logic [2:0][7:0]  res;
    logic [2:0][15:0] sy;
    logic [2:0][31:0] sp;
    logic [2:0][9:0]  ct;
    logic [2:0][7:0]  cm;
    logic [2:0][14:0] rem;
    logic [2:0][8:0]  dv;
    logic [2:0][7:0]  q;
    logic [2:0]       covf;
  } pix_t;

  function automatic logic [7:0] clamp10(input logic [9:0] v);
    clamp10 = (v > {2'b00, MAXV}) ? MAXV : v[7:0];
  endfunction

endpackage

FILE: sv/pixel_color_effects.sv
// Pixel color effects: invert, decolor, sepia, cast, freeze, comic.
// Depends on pce_pkg and pixel_color_effects_macros.svh.
//
// Usage:
//   in_*  : pixel stream, tdata = {blue, green, red}, red in bits 7:0.
//   out_* : result stream, same packing, one result per input transfer.
//   cfg_* : effect_mode write channel, always ready; write only while idle.
// From an input transfer to its result a pixel passes one setup stage, eight
// stages of the restoring divider used by the cast effect (one quotient bit
// per stage) and one output stage. Throughput is one pixel per cycle while
// the output is not stalled. The whole pipeline advances together; when
// out_tvalid is high and out_tready low, in_tready drops and every stage
// holds, so nothing is lost or repeated.
// Reset clears all valid bits and sets effect_mode to invert.
// Modes 6 and 7 pass the pixel through.
module pixel_color_effects
  import pce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in, green_in, blue_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red_out, green_out, blue_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data    // effect_mode
);

  localparam int NDIV = DIV_STEPS;
  localparam int NST = NDIV + 1;

  logic [2:0]  mode_r;
  pix_t        st_r   [NST];
  pix_t        st_nxt [NST];
  pix_t        st0_nxt;
  logic [NST-1:0] v_r;
  logic        out_tvalid_r;
  logic [23:0] out_tdata_r;
  logic [23:0] out_tdata_nxt;
  logic        ce;

  assign ce         = !out_tvalid_r || out_tready;
  assign in_tready  = ce;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_INVERT;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  // setup stage
  always_comb begin
    logic [2:0][7:0] c;
    logic [2:0][7:0] a;
    logic [2:0][7:0] b;
    logic [7:0]  mn, mx;
    logic [8:0]  oth, df;
    logic [9:0]  f3;
    logic [18:0] s0, s1, s2;
    logic [9:0]  p1, p2;
    c = in_tdata;
    a = {c[0], c[0], c[1]};
    b = {c[1], c[2], c[2]};
    st0_nxt = '0;
    st0_nxt.mode = mode_t'(mode_r);
    mn = c[0];
    mx = c[0];
    for (int i = 1; i < 3; i++) begin
      if (c[i] < mn) mn = c[i];
      if (c[i] > mx) mx = c[i];
    end
    for (int i = 0; i < 3; i++) begin
      oth = {1'b0, a[i]} + {1'b0, b[i]};
      st0_nxt.dv[i]   = oth + 9'd1;
      st0_nxt.rem[i]  = {c[i], 7'd0};
      st0_nxt.covf[i] = {2'b00, c[i]} >= {st0_nxt.dv[i], 1'b0};
      df = {1'b0, c[i]} - oth;
      f3 = ({1'b0, df} + {df, 1'b0}) >> 1;
      case (mode_r)
        MODE_INVERT:  st0_nxt.res[i] = MAXV - c[i];
        MODE_DECOLOR: st0_nxt.res[i] = 8'(({1'b0, mn} + {1'b0, mx}) >> 1);
        MODE_FREEZE:  st0_nxt.res[i] = ({1'b0, c[i]} > oth) ? clamp10(f3) : 8'd0;
        default:      st0_nxt.res[i] = c[i];
      endcase
    end
    s0 = 19'(SEP_R0 * c[0]) + 19'(SEP_G0 * c[1]) + 19'(SEP_B0 * c[2]);
    s1 = 19'(SEP_R1 * c[0]) + 19'(SEP_G1 * c[1]) + 19'(SEP_B1 * c[2]);
    s2 = 19'(SEP_R2 * c[0]) + 19'(SEP_G2 * c[1]) + 19'(SEP_B2 * c[2]);
    st0_nxt.sy[0] = s0[18:3];
    st0_nxt.sy[1] = s1[18:3];
    st0_nxt.sy[2] = s2[18:3];
    p1 = {1'b0, c[1], 1'b0} + {2'b00, c[0]};
    p2 = {1'b0, c[2], 1'b0} + {2'b00, c[0]};
    st0_nxt.ct[0] = (p1 >= {2'b00, c[2]}) ? p1 - {2'b00, c[2]} : {2'b00, c[2]} - p1;
    st0_nxt.ct[1] = (p2 >= {2'b00, c[1]}) ? p2 - {2'b00, c[1]} : {2'b00, c[1]} - p2;
    st0_nxt.ct[2] = st0_nxt.ct[1];
    st0_nxt.cm = {c[1], c[0], c[0]};
  end

  // divider stages; sepia and comic products finish along the way
  always_comb begin
    logic [16:0] trial;
    logic [17:0] cp;
    cp = '0;
    st_nxt[0] = st0_nxt;
    for (int s = 1; s < NST; s++) begin
      st_nxt[s] = st_r[s-1];
      for (int i = 0; i < 3; i++) begin
        trial = 17'({8'd0, st_r[s-1].dv[i]} << (NDIV - s));
        if ({2'b00, st_r[s-1].rem[i]} >= trial) begin
          st_nxt[s].rem[i] = st_r[s-1].rem[i] - trial[14:0];
          st_nxt[s].q[i][NDIV-s] = 1'b1;
        end
        if (s == 1) begin
          st_nxt[s].sp[i] = st_r[s-1].sy[i] * SEP_RECIP;
          cp = st_r[s-1].ct[i] * st_r[s-1].cm[i];
          if (st_r[s-1].mode == MODE_COMIC) st_nxt[s].res[i] = clamp10(cp[17:8]);
        end
        if (s == 2 && st_r[s-1].mode == MODE_SEPIA) begin
          st_nxt[s].res[i] = clamp10(st_r[s-1].sp[i][SEP_SHIFT+9:SEP_SHIFT]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (st_r[NST-1].mode == MODE_CAST) begin
        out_tdata_nxt[i*8 +: 8] = st_r[NST-1].covf[i] ? MAXV : st_r[NST-1].q[i];
      end else begin
        out_tdata_nxt[i*8 +: 8] = st_r[NST-1].res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int s = 0; s < NST; s++) st_r[s] <= st_nxt[s];
      out_tdata_r <= out_tdata_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else if (ce) begin
      v_r          <= {v_r[NST-2:0], in_tvalid};
      out_tvalid_r <= v_r[NST-1];
    end
  end

  `include "pixel_color_effects_macros.svh"

  `PCE_ASSERT_NEXT(a_stall_holds, clk, rst_n, !ce, $stable(v_r))
  `PCE_ASSERT_NEXT(a_stall_cause, clk, rst_n, !in_tready, out_tvalid)
  `PCE_ASSERT_NEXT(a_cast_clamp, clk, rst_n,
    ce && v_r[NST-1] && st_r[NST-1].mode == MODE_CAST && st_r[NST-1].covf[0],
    out_tdata[7:0] == MAXV)

endmodule
